// File: rtl/slw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slw_pkg: shared types and constants for the spectrum low-pass weighting core
// Field widths, intermediate widths of the gain datapath, register indexes.
// ----------------------------------------------------------------------------
package slw_pkg;

  localparam int unsigned DATA_W    = 32;   // bin part width, signed
  localparam int unsigned GAIN_FRAC = 16;   // fraction bits of the gain
  localparam int unsigned GAIN_W    = GAIN_FRAC + 1;
  localparam int unsigned MAX_ROWS  = 1024;
  localparam int unsigned MAX_COLS  = 1024;

  localparam int unsigned DIM_W     = 11;   // row_count / col_count
  localparam int unsigned POS_W     = 10;   // row_index / col_index
  localparam int unsigned SPC_W     = 6;    // cut_spacing
  localparam int unsigned K_W       = SPC_W + 1;
  localparam int unsigned KK_W      = 2 * K_W;
  localparam int unsigned SQ_W      = 21;   // rows^2, cols^2 (up to 2^20)
  localparam int unsigned PSQ_W     = 2 * POS_W;
  localparam int unsigned KR_W      = 34;   // k^2 * rows^2
  localparam int unsigned CROSS_W   = 40;   // dh^2*cols^2, col^2*rows^2
  localparam int unsigned SUM_W     = CROSS_W + 1;
  localparam int unsigned NUM_W     = 54;
  localparam int unsigned DEN_W     = 55;
  localparam int unsigned REM_W     = DEN_W + 1;
  localparam int unsigned PROD_W    = DATA_W + GAIN_W + 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DIM_W;

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - 2 * DATA_W - GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT   = 2'd0,
    REG_COL_COUNT   = 2'd1,
    REG_CUT_SPACING = 2'd2
  } cfg_reg_e;

  // data that rides along the divider
  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     oor;    // position outside the configured size
    logic                     unity;  // gain forced to one
  } side_t;

endpackage

// File: rtl/slw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slw_div: pipelined restoring divider for the gain fraction
// One quotient bit per stage: floor(2^GAIN_FRAC * num / den) for num < den.
// ----------------------------------------------------------------------------
module slw_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         up_valid_i,
  output logic                         up_ready_o,
  input  logic [slw_pkg::NUM_W-1:0]    num_i,
  input  logic [slw_pkg::DEN_W-1:0]    den_i,
  input  slw_pkg::side_t               side_i,
  output logic                         dn_valid_o,
  input  logic                         dn_ready_i,
  output logic [slw_pkg::GAIN_FRAC-1:0] quo_o,
  output slw_pkg::side_t               side_o
);
  import slw_pkg::*;

  localparam int unsigned NSTG = GAIN_FRAC;

  logic                 vld_q  [NSTG];
  logic [REM_W-1:0]     rem_q  [NSTG];
  logic [DEN_W-1:0]     den_q  [NSTG];
  logic [GAIN_FRAC-1:0] quo_q  [NSTG];
  side_t                side_q [NSTG];

  logic                 src_vld  [NSTG];
  logic [REM_W-1:0]     src_rem  [NSTG];
  logic [DEN_W-1:0]     src_den  [NSTG];
  logic [GAIN_FRAC-1:0] src_quo  [NSTG];
  side_t                src_side [NSTG];

  logic [REM_W-1:0]     rem_d [NSTG];
  logic [GAIN_FRAC-1:0] quo_d [NSTG];

  wire [NSTG:0] adv;

  assign adv[NSTG] = dn_ready_i;

  // a stage moves when it is empty or the next one moves
  for (genvar i = 0; i < NSTG; i++) begin : g_adv
    assign adv[i] = !vld_q[i] || adv[i+1];
  end

  always_comb begin
    logic [REM_W-1:0] shifted;
    logic             take;
    shifted = '0;
    take    = 1'b0;
    for (int i = 0; i < NSTG; i++) begin
      if (i == 0) begin
        src_vld[i]  = up_valid_i;
        src_rem[i]  = REM_W'(num_i);
        src_den[i]  = den_i;
        src_quo[i]  = '0;
        src_side[i] = side_i;
      end else begin
        src_vld[i]  = vld_q[i-1];
        src_rem[i]  = rem_q[i-1];
        src_den[i]  = den_q[i-1];
        src_quo[i]  = quo_q[i-1];
        src_side[i] = side_q[i-1];
      end
      shifted  = {src_rem[i][REM_W-2:0], 1'b0};
      take     = shifted >= REM_W'(src_den[i]);
      rem_d[i] = take ? shifted - REM_W'(src_den[i]) : shifted;
      quo_d[i] = {src_quo[i][GAIN_FRAC-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) vld_q[i] <= 1'b0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) vld_q[i] <= src_vld[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NSTG; i++) begin
      if (adv[i] && src_vld[i]) begin
        rem_q[i]  <= rem_d[i];
        den_q[i]  <= src_den[i];
        quo_q[i]  <= quo_d[i];
        side_q[i] <= src_side[i];
      end
    end
  end

  assign up_ready_o = adv[0];
  assign dn_valid_o = vld_q[NSTG-1];
  assign quo_o      = quo_q[NSTG-1];
  assign side_o     = side_q[NSTG-1];

  // the partial remainder stays below the divisor on every real division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dn_valid_o && !side_o.unity |-> rem_q[NSTG-1] < REM_W'(den_q[NSTG-1]))
    else $error("divider remainder not below divisor");

  // the divider only backs up when its output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !up_ready_o |-> dn_valid_o && !dn_ready_i)
    else $error("divider stalled without downstream backpressure");

endmodule

// File: rtl/spectrum_lowpass_weighting_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_lowpass_weighting_core: first-order low-pass gain on spectrum bins
// Pipeline: 4 gain stages, 16 divider stages, one multiply stage, the output
//   register.
// Throughput: one beat per cycle unless m_axis_tready holds the output; the 16-stage divider sets the depth.
// Reset: clears all stage valid bits; rows 256, columns 129, spacing 3.
// ----------------------------------------------------------------------------
module spectrum_lowpass_weighting_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [slw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [slw_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // re_in[31:0], im_in[63:32], row_index[73:64], col_index[83:74], zero pad
  input  logic [slw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // re_out[31:0], im_out[63:32], gain_applied[80:64], zero pad
  output logic [slw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // out_of_range[0]
  output logic                              m_axis_tuser
);
  import slw_pkg::*;

  // configuration
  logic [DIM_W-1:0] row_cnt_q, row_cnt_d;
  logic [DIM_W-1:0] col_cnt_q, col_cnt_d;
  logic [SPC_W-1:0] spacing_q, spacing_d;

  always_comb begin
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    spacing_d = spacing_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ROW_COUNT:   row_cnt_d = cfg_wdata_i;
        REG_COL_COUNT:   col_cnt_d = cfg_wdata_i;
        REG_CUT_SPACING: spacing_d = cfg_wdata_i[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= DIM_W'(256);
      col_cnt_q <= DIM_W'(129);
      spacing_q <= SPC_W'(3);
    end else begin
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      spacing_q <= spacing_d;
    end
  end

  logic [DIM_W-1:0] rows_eff, cols_eff;
  assign rows_eff = (row_cnt_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : row_cnt_q;
  assign cols_eff = (col_cnt_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : col_cnt_q;

  // handshake chain
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, out_vld_q;
  logic s1_adv, s2_adv, s3_adv, s4_adv, s5_adv, out_adv;
  logic div_up_ready, div_dn_valid;

  assign out_adv = !out_vld_q || m_axis_tready;
  assign s5_adv  = !s5_vld_q || out_adv;
  assign s4_adv  = !s4_vld_q || div_up_ready;
  assign s3_adv  = !s3_vld_q || s4_adv;
  assign s2_adv  = !s2_vld_q || s3_adv;
  assign s1_adv  = !s1_vld_q || s2_adv;
  assign s_axis_tready = s1_adv;

  // ---- stage 1: range check, row distance, squares
  logic signed [DATA_W-1:0] in_re, in_im;
  logic [POS_W-1:0]         in_row, in_col, dh;
  logic                     in_oor;
  logic [K_W-1:0]           k_val;

  assign in_re  = s_axis_tdata[DATA_W-1:0];
  assign in_im  = s_axis_tdata[2*DATA_W-1:DATA_W];
  assign in_row = s_axis_tdata[2*DATA_W+POS_W-1:2*DATA_W];
  assign in_col = s_axis_tdata[2*DATA_W+2*POS_W-1:2*DATA_W+POS_W];

  assign in_oor = ({1'b0, in_row} >= rows_eff) || ({1'b0, in_col} >= cols_eff);
  // rows from rows/2 up fold back with the extra minus one
  assign dh = ({1'b0, in_row} < (rows_eff >> 1)) ? in_row
            : POS_W'(rows_eff - {1'b0, in_row} - DIM_W'(1));
  assign k_val = {spacing_q, 1'b0};

  logic signed [DATA_W-1:0] s1_re_q, s1_im_q;
  logic                     s1_oor_q;
  logic [PSQ_W-1:0]         s1_dh2_q, s1_col2_q, s1_dh2_d, s1_col2_d;
  logic [SQ_W-1:0]          s1_r2_q, s1_c2_q, s1_r2_d, s1_c2_d;
  logic [KK_W-1:0]          s1_kk_q, s1_kk_d;

  assign s1_dh2_d  = PSQ_W'(dh) * PSQ_W'(dh);
  assign s1_col2_d = PSQ_W'(in_col) * PSQ_W'(in_col);
  assign s1_r2_d   = SQ_W'(rows_eff) * SQ_W'(rows_eff);
  assign s1_c2_d   = SQ_W'(cols_eff) * SQ_W'(cols_eff);
  assign s1_kk_d   = KK_W'(k_val) * KK_W'(k_val);

  always_ff @(posedge clk_i) begin
    if (s1_adv && s_axis_tvalid) begin
      s1_re_q   <= in_re;
      s1_im_q   <= in_im;
      s1_oor_q  <= in_oor;
      s1_dh2_q  <= s1_dh2_d;
      s1_col2_q <= s1_col2_d;
      s1_r2_q   <= s1_r2_d;
      s1_c2_q   <= s1_c2_d;
      s1_kk_q   <= s1_kk_d;
    end
  end

  // ---- stage 2: cross products
  logic signed [DATA_W-1:0] s2_re_q, s2_im_q;
  logic                     s2_oor_q;
  logic [KR_W-1:0]          s2_kr_q, s2_kr_d;
  logic [CROSS_W-1:0]       s2_rowt_q, s2_rowt_d, s2_colt_q, s2_colt_d;
  logic [SQ_W-1:0]          s2_c2_q;

  assign s2_kr_d   = KR_W'(s1_kk_q) * KR_W'(s1_r2_q);
  assign s2_rowt_d = CROSS_W'(s1_dh2_q) * CROSS_W'(s1_c2_q);
  assign s2_colt_d = CROSS_W'(s1_col2_q) * CROSS_W'(s1_r2_q);

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_vld_q) begin
      s2_re_q   <= s1_re_q;
      s2_im_q   <= s1_im_q;
      s2_oor_q  <= s1_oor_q;
      s2_kr_q   <= s2_kr_d;
      s2_rowt_q <= s2_rowt_d;
      s2_colt_q <= s2_colt_d;
      s2_c2_q   <= s1_c2_q;
    end
  end

  // ---- stage 3: numerator and distance sum
  logic signed [DATA_W-1:0] s3_re_q, s3_im_q;
  logic                     s3_oor_q;
  logic [NUM_W-1:0]         s3_num_q, s3_num_d;
  logic [SUM_W-1:0]         s3_sum_q, s3_sum_d;

  assign s3_num_d = NUM_W'(s2_kr_q) * NUM_W'(s2_c2_q);
  assign s3_sum_d = SUM_W'(s2_rowt_q) + SUM_W'(s2_colt_q);

  always_ff @(posedge clk_i) begin
    if (s3_adv && s2_vld_q) begin
      s3_re_q  <= s2_re_q;
      s3_im_q  <= s2_im_q;
      s3_oor_q <= s2_oor_q;
      s3_num_q <= s3_num_d;
      s3_sum_q <= s3_sum_d;
    end
  end

  // ---- stage 4: denominator; zero distance gives a gain of one
  logic [NUM_W-1:0] s4_num_q;
  logic [DEN_W-1:0] s4_den_q, s4_den_d;
  side_t            s4_side_q, s4_side_d;

  assign s4_den_d = DEN_W'(s3_num_q) + DEN_W'(s3_sum_q);

  always_comb begin
    s4_side_d.re    = s3_re_q;
    s4_side_d.im    = s3_im_q;
    s4_side_d.oor   = s3_oor_q;
    s4_side_d.unity = s3_oor_q || (s3_sum_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (s4_adv && s3_vld_q) begin
      s4_num_q  <= s3_num_q;
      s4_den_q  <= s4_den_d;
      s4_side_q <= s4_side_d;
    end
  end

  // ---- divider
  logic [GAIN_FRAC-1:0] div_quo;
  side_t                div_side;

  slw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (s4_vld_q),
    .up_ready_o (div_up_ready),
    .num_i      (s4_num_q),
    .den_i      (s4_den_q),
    .side_i     (s4_side_q),
    .dn_valid_o (div_dn_valid),
    .dn_ready_i (s5_adv),
    .quo_o      (div_quo),
    .side_o     (div_side)
  );

  // ---- stage 5: weight both parts
  logic [GAIN_W-1:0]        s5_gain_d, s5_gain_q;
  logic signed [PROD_W-1:0] s5_pre_d, s5_pim_d, s5_pre_q, s5_pim_q;
  logic signed [DATA_W-1:0] s5_re_q, s5_im_q;
  logic                     s5_oor_q, s5_unity_q;

  assign s5_gain_d = div_side.unity ? GAIN_ONE : {1'b0, div_quo};
  assign s5_pre_d  = PROD_W'(div_side.re) * PROD_W'($signed({1'b0, s5_gain_d}));
  assign s5_pim_d  = PROD_W'(div_side.im) * PROD_W'($signed({1'b0, s5_gain_d}));

  always_ff @(posedge clk_i) begin
    if (s5_adv && div_dn_valid) begin
      s5_gain_q  <= s5_gain_d;
      s5_pre_q   <= s5_pre_d;
      s5_pim_q   <= s5_pim_d;
      s5_re_q    <= div_side.re;
      s5_im_q    <= div_side.im;
      s5_oor_q   <= div_side.oor;
      s5_unity_q <= div_side.unity;
    end
  end

  // ---- output register: pass through at unity, else floor of product
  logic signed [DATA_W-1:0] out_re_q, out_im_q, out_re_d, out_im_d;
  logic [GAIN_W-1:0]        out_gain_q;
  logic                     out_oor_q;

  assign out_re_d = s5_unity_q ? s5_re_q : s5_pre_q[GAIN_FRAC +: DATA_W];
  assign out_im_d = s5_unity_q ? s5_im_q : s5_pim_q[GAIN_FRAC +: DATA_W];

  always_ff @(posedge clk_i) begin
    if (out_adv && s5_vld_q) begin
      out_re_q   <= out_re_d;
      out_im_q   <= out_im_d;
      out_gain_q <= s5_gain_q;
      out_oor_q  <= s5_oor_q;
    end
  end

  // valid bits advance with their stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_adv)  s1_vld_q  <= s_axis_tvalid;
      if (s2_adv)  s2_vld_q  <= s1_vld_q;
      if (s3_adv)  s3_vld_q  <= s2_vld_q;
      if (s4_adv)  s4_vld_q  <= s3_vld_q;
      if (s5_adv)  s5_vld_q  <= div_dn_valid;
      if (out_adv) out_vld_q <= s5_vld_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_gain_q, out_im_q, out_re_q};
  assign m_axis_tuser  = out_oor_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2*DATA_W +: GAIN_W] == GAIN_ONE)
    else $error("out-of-range beat without unity gain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2*DATA_W +: GAIN_W] <= GAIN_ONE)
    else $error("gain above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: spectrum_lowpass_weighting_core
// Streams spectrum bins through the core under several size and spacing
// settings, including zero, minimum, maximum and oversized ones. A scoreboard
// computes the weighted bin for every accepted input beat and checks the
// output beats against those bins in order. Both stream sides idle at random,
// and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import slw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;  // no register behind it
  localparam int unsigned          HOLD_AFTER  = 500;   // input beats before the hold-off
  localparam int unsigned          HOLD_CYCLES = 300;
  localparam logic [DATA_W-1:0]    MOST_POS    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0]    MOST_NEG    = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0]    MINUS_ONE   = '1;

  typedef struct {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic [GAIN_W-1:0] gain;
    logic              oor;
  } weighted_bin_t;

  class weighting_scoreboard;
    longint unsigned row_count;
    longint unsigned col_count;
    longint unsigned cut_spacing;
    weighted_bin_t   weighted_q[$];
    int unsigned     bins_in;
    int unsigned     errors;

    function new();
      row_count   = 256;
      col_count   = 129;
      cut_spacing = 3;
      bins_in     = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ROW_COUNT:   row_count   = val;
        REG_COL_COUNT:   col_count   = val;
        REG_CUT_SPACING: cut_spacing = val[SPC_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(part * gain / 2^GAIN_FRAC) on the signed part
    function logic [DATA_W-1:0] scale_part(logic [DATA_W-1:0] part, longint unsigned gain);
      longint prod;
      prod = longint'(signed'(part)) * longint'(gain);
      return DATA_W'(prod >>> GAIN_FRAC);
    endfunction

    function void note_bin(logic [DATA_W-1:0] re, logic [DATA_W-1:0] im,
                           logic [POS_W-1:0] row, logic [POS_W-1:0] col);
      longint unsigned rows, cols, dh, k, r2, c2, num, den, gain, c;
      logic [127:0]    quot;
      weighted_bin_t   w;
      rows = (row_count > MAX_ROWS) ? MAX_ROWS : row_count;
      cols = (col_count > MAX_COLS) ? MAX_COLS : col_count;
      bins_in++;
      if (row >= rows || col >= cols) begin
        w.re   = re;
        w.im   = im;
        w.gain = GAIN_ONE;
        w.oor  = 1'b1;
      end else begin
        // rows from rows/2 up mirror with the extra minus one
        dh   = (row < rows / 2) ? row : rows - row - 1;
        c    = col;
        k    = 2 * cut_spacing;
        r2   = rows * rows;
        c2   = cols * cols;
        num  = k * k * r2 * c2;
        den  = num + dh * dh * c2 + c * c * r2;
        if (num >= den) begin
          gain = longint'(1) << GAIN_FRAC;
        end else begin
          quot = (128'(num) << GAIN_FRAC) / 128'(den);
          gain = quot[63:0];
        end
        w.re   = scale_part(re, gain);
        w.im   = scale_part(im, gain);
        w.gain = GAIN_W'(gain);
        w.oor  = 1'b0;
      end
      weighted_q.push_back(w);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
      weighted_bin_t     w;
      logic [DATA_W-1:0] re, im;
      logic [GAIN_W-1:0] gain;
      if (weighted_q.size() == 0) begin
        $error("output beat with no bin pending: tdata %h tuser %b", tdata, tuser);
        errors++;
        return;
      end
      w    = weighted_q.pop_front();
      re   = tdata[DATA_W-1:0];
      im   = tdata[2*DATA_W-1:DATA_W];
      gain = tdata[2*DATA_W+GAIN_W-1:2*DATA_W];
      if (re !== w.re) begin
        $error("re_out: expected %0d, got %0d", $signed(w.re), $signed(re));
        errors++;
      end
      if (im !== w.im) begin
        $error("im_out: expected %0d, got %0d", $signed(w.im), $signed(im));
        errors++;
      end
      if (gain !== w.gain) begin
        $error("gain_applied: expected %0d, got %0d", w.gain, gain);
        errors++;
      end
      if (tuser !== w.oor) begin
        $error("out_of_range: expected %0d, got %0d", w.oor, tuser);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  weighting_scoreboard sb = new();
  bit                  send_burst;

  spectrum_lowpass_weighting_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(8_000_000);
    $display("** spectrum_lowpass_weighting_core: FAILED **");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned calm_left;
    bit          held;
    hold_left     = 0;
    calm_left     = 0;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!held && sb.bins_in >= HOLD_AFTER) begin
        // hold off while input keeps coming, so the pipeline fills and stalls
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left--;
        m_axis_tready <= 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            calm_left = $urandom_range(20, 150);
            m_axis_tready <= 1'b1;
          end
          2, 3, 4, 5: m_axis_tready <= 1'b1;
          6, 7, 8:    m_axis_tready <= 1'b0;
          default: begin
            hold_left = $urandom_range(5, 40);
            m_axis_tready <= 1'b0;
          end
        endcase
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_size(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols,
                          logic [CFG_DATA_W-1:0] spacing);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    write_reg(REG_CUT_SPACING, spacing);
  endtask

  // offer one beat and hold it until accepted; valid stays high for the caller
  task automatic send_bin(logic [DATA_W-1:0] re, logic [DATA_W-1:0] im,
                          logic [POS_W-1:0] row, logic [POS_W-1:0] col);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({col, row, im, re});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_bin(re, im, row, col);
  endtask

  task automatic pause_sender();
    int unsigned gap, pick;
    pick = $urandom_range(0, 99);
    if (send_burst || pick < 55) gap = 0;
    else if (pick < 90)          gap = $urandom_range(1, 3);
    else                         gap = $urandom_range(8, 40);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_bins();
    s_axis_tvalid <= 1'b0;
    while (sb.weighted_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] random_part();
    case ($urandom_range(0, 7))
      0:       return MOST_POS;
      1:       return MOST_NEG;
      2:       return DATA_W'($urandom_range(0, 3)) - 1;
      3:       return DATA_W'($urandom_range(0, 4095)) - 2048;
      default: return $urandom();
    endcase
  endfunction

  // mostly inside the configured size, with its edges, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_pos(longint unsigned size);
    int unsigned pick;
    pick = $urandom_range(0, 11);
    if (size == 0 || pick == 0) return POS_W'($urandom_range(0, 1023));
    if (pick == 1) return POS_W'(size - 1);
    if (pick == 2) return POS_W'(size / 2);
    if (pick == 3) return POS_W'((size - 1) / 2);
    if (pick == 4) return POS_W'(size);
    return POS_W'($urandom_range(0, int'(size) - 1));
  endfunction

  task automatic run_random(int unsigned count);
    longint unsigned   rows, cols;
    logic [DATA_W-1:0] re, im;
    logic [POS_W-1:0]  row, col;
    int unsigned       i;
    rows = (sb.row_count > MAX_ROWS) ? MAX_ROWS : sb.row_count;
    cols = (sb.col_count > MAX_COLS) ? MAX_COLS : sb.col_count;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) send_burst = ($urandom_range(0, 2) == 0);
      re  = random_part();
      im  = random_part();
      row = pick_pos(rows);
      col = pick_pos(cols);
      if (i != 0) pause_sender();
      send_bin(re, im, row, col);
    end
    drain_bins();
  endtask

  initial begin : stimulus
    int unsigned n;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    send_burst    = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes: corner, both halves, last row and column, outside
    send_bin(MOST_POS, MOST_NEG, 0, 0);
    send_bin(MOST_NEG, MOST_POS, 127, 0);
    send_bin(MINUS_ONE, 1, 128, 0);
    send_bin(MOST_POS, MINUS_ONE, 255, 128);
    send_bin(MOST_NEG, MOST_NEG, 200, 77);
    send_bin(0, 0, 60, 100);
    send_bin(MOST_POS, MOST_NEG, 256, 0);
    send_bin(MOST_NEG, MOST_POS, 0, 129);
    send_bin(MINUS_ONE, 5, 1023, 1023);
    drain_bins();
    run_random(150);

    set_size(1024, 1024, 63);
    run_random(150);

    set_size(1, 1, 1);
    run_random(100);

    // oversized dimensions with zero spacing: gain zero except at the two zero-distance corners
    set_size(2047, 2047, 0);
    send_bin(MOST_POS, MOST_NEG, 0, 0);
    send_bin(MOST_POS, MOST_NEG, 0, 1);
    send_bin(MOST_NEG, MINUS_ONE, 1023, 0);
    drain_bins();
    run_random(150);

    // zero rows, then zero columns: everything falls outside
    set_size(0, 17, 5);
    run_random(50);
    set_size(900, 0, 9);
    run_random(50);

    set_size(1500, 600, 1);
    run_random(100);

    for (n = 0; n < 5; n++) begin
      set_size(CFG_DATA_W'($urandom_range(1, 1024)), CFG_DATA_W'($urandom_range(1, 1024)),
               CFG_DATA_W'($urandom_range(0, 2047)));
      write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
      run_random(120);
    end

    repeat (30) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** spectrum_lowpass_weighting_core: PASSED **");
    end else begin
      $display("** spectrum_lowpass_weighting_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/slw_pkg.sv
rtl/slw_div.sv
rtl/spectrum_lowpass_weighting_core.sv
verif/testbench.sv
